>>> hdl/lom_pkg.sv
// Shared types and constants for the limit order matcher.
// Depends on nothing; every other file in hdl/ refers to it by scoped names.
package lom_pkg;

   localparam int DEFAULT_BOOK_DEPTH = 64;
   localparam int PRICE_W            = 32;
   localparam int QTY_W              = 32;

   typedef struct packed {
      logic               is_buy;
      logic [PRICE_W-1:0] limit_price;
      logic [QTY_W-1:0]   order_quantity;
   } req_type;

   typedef struct packed {
      logic [QTY_W-1:0]   filled_quantity;
      logic [QTY_W-1:0]   rested_quantity;
      logic [QTY_W-1:0]   dropped_quantity;
      logic [PRICE_W-1:0] top_bid_price;
      logic               bid_present;
      logic [PRICE_W-1:0] top_ask_price;
      logic               ask_present;
   } rsp_type;

   typedef struct packed {
      logic [PRICE_W-1:0] price;
      logic [QTY_W-1:0]   qty;
   } entry_type;

endpackage

>>> hdl/lom_req_fifo.sv
// Front end: two-entry request queue that decouples intake from the book engine.
// Depends on lom_pkg for the request type.
module lom_req_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  lom_pkg::req_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output lom_pkg::req_type out_data
);

   lom_pkg::req_type slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;
   logic             push, pop;

   assign in_ready  = (fill_ff != 2'd2);
   assign out_valid = (fill_ff != 2'd0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

>>> hdl/lom_engine.sv
// Back end: both order books in circular memories, matching and sorted insertion.
// Depends on lom_pkg for request, result and entry types.
module lom_engine #(
   parameter int BookDepth = lom_pkg::DEFAULT_BOOK_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  lom_pkg::req_type in_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lom_pkg::rsp_type rsp_data
);

   localparam int IW = (BookDepth > 1) ? $clog2(BookDepth) : 1;
   localparam int CW = $clog2(BookDepth + 1);
   localparam logic [CW:0]   DEPTH_S = (CW + 1)'(BookDepth);
   localparam logic [CW-1:0] DEPTH_C = CW'(BookDepth);
   localparam logic [CW-1:0] ONE_C   = CW'(1);
   localparam int PW = lom_pkg::PRICE_W;
   localparam int QW = lom_pkg::QTY_W;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_MATCH = 7'b0000010,
      ST_LOAD  = 7'b0000100,
      ST_PLACE = 7'b0001000,
      ST_SHIFT = 7'b0010000,
      ST_WRITE = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   // Physical slot of a logical position behind the head of a circular book.
   function automatic logic [IW-1:0] phys(input logic [IW-1:0] head,
                                          input logic [CW-1:0] pos);
      logic [CW:0] sum;
      sum = (CW + 1)'(head) + (CW + 1)'(pos);
      if (sum >= DEPTH_S) begin
         sum = sum - DEPTH_S;
      end
      return sum[IW-1:0];
   endfunction

   state_type state_ff, state_in;

   logic          buy_ff, buy_in;
   logic [PW-1:0] limit_ff, limit_in;
   logic [QW-1:0] qty_ff, qty_in;
   logic [QW-1:0] rem_ff, rem_in;
   logic [QW-1:0] rested_ff, rested_in;
   logic [QW-1:0] dropped_ff, dropped_in;
   logic [CW-1:0] idx_ff, idx_in;

   logic [IW-1:0] bid_head_ff, bid_head_in, ask_head_ff, ask_head_in;
   logic [CW-1:0] bid_cnt_ff, bid_cnt_in, ask_cnt_ff, ask_cnt_in;
   logic [PW-1:0] bid_hp_ff, bid_hp_in, ask_hp_ff, ask_hp_in;
   logic [QW-1:0] bid_hq_ff, bid_hq_in, ask_hq_ff, ask_hq_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   lom_pkg::rsp_type     rsp_data_ff, rsp_data_in;

   lom_pkg::entry_type   bid_mem [BookDepth];
   lom_pkg::entry_type   ask_mem [BookDepth];
   lom_pkg::entry_type   bid_rd_ff, ask_rd_ff;

   logic                 we_bid, we_ask;
   logic [IW-1:0]        wr_addr, rd_addr;
   lom_pkg::entry_type   wr_data;

   logic [CW-1:0]        opp_cnt, own_cnt;
   logic [IW-1:0]        opp_head, own_head;
   logic [PW-1:0]        opp_hp;
   logic [QW-1:0]        opp_hq;
   lom_pkg::entry_type   opp_rd, own_rd;
   logic                 crosses, worse;

   assign in_ready  = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      opp_cnt  = buy_ff ? ask_cnt_ff  : bid_cnt_ff;
      opp_head = buy_ff ? ask_head_ff : bid_head_ff;
      opp_hp   = buy_ff ? ask_hp_ff   : bid_hp_ff;
      opp_hq   = buy_ff ? ask_hq_ff   : bid_hq_ff;
      own_cnt  = buy_ff ? bid_cnt_ff  : ask_cnt_ff;
      own_head = buy_ff ? bid_head_ff : ask_head_ff;
      opp_rd   = buy_ff ? ask_rd_ff   : bid_rd_ff;
      own_rd   = buy_ff ? bid_rd_ff   : ask_rd_ff;
      crosses  = buy_ff ? (opp_hp <= limit_ff) : (opp_hp >= limit_ff);
      worse    = buy_ff ? (own_rd.price < limit_ff) : (own_rd.price > limit_ff);
   end

   always_comb begin
      state_in     = state_ff;
      buy_in       = buy_ff;
      limit_in     = limit_ff;
      qty_in       = qty_ff;
      rem_in       = rem_ff;
      rested_in    = rested_ff;
      dropped_in   = dropped_ff;
      idx_in       = idx_ff;
      bid_head_in  = bid_head_ff;
      ask_head_in  = ask_head_ff;
      bid_cnt_in   = bid_cnt_ff;
      ask_cnt_in   = ask_cnt_ff;
      bid_hp_in    = bid_hp_ff;
      ask_hp_in    = ask_hp_ff;
      bid_hq_in    = bid_hq_ff;
      ask_hq_in    = ask_hq_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      we_bid       = 1'b0;
      we_ask       = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_addr      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (in_valid) begin
               buy_in     = in_data.is_buy;
               limit_in   = in_data.limit_price;
               qty_in     = in_data.order_quantity;
               rem_in     = in_data.order_quantity;
               rested_in  = '0;
               dropped_in = '0;
               state_in   = ST_MATCH;
            end
         end
         ST_MATCH: begin
            if (opp_cnt == '0 || rem_ff == '0 || !crosses) begin
               state_in = ST_PLACE;
            end else if (opp_hq > rem_ff) begin
               // Partial fill of the head: shrink it in cache and memory.
               wr_addr = opp_head;
               wr_data = '{price: opp_hp, qty: opp_hq - rem_ff};
               if (buy_ff) begin
                  ask_hq_in = opp_hq - rem_ff;
                  we_ask    = 1'b1;
               end else begin
                  bid_hq_in = opp_hq - rem_ff;
                  we_bid    = 1'b1;
               end
               rem_in   = '0;
               state_in = ST_PLACE;
            end else begin
               // Head fully consumed: advance and fetch the next head.
               rem_in  = rem_ff - opp_hq;
               rd_addr = phys(opp_head, ONE_C);
               if (buy_ff) begin
                  ask_head_in = phys(opp_head, ONE_C);
                  ask_cnt_in  = opp_cnt - ONE_C;
               end else begin
                  bid_head_in = phys(opp_head, ONE_C);
                  bid_cnt_in  = opp_cnt - ONE_C;
               end
               state_in = (opp_cnt > ONE_C) ? ST_LOAD : ST_MATCH;
            end
         end
         ST_LOAD: begin
            if (buy_ff) begin
               ask_hp_in = opp_rd.price;
               ask_hq_in = opp_rd.qty;
            end else begin
               bid_hp_in = opp_rd.price;
               bid_hq_in = opp_rd.qty;
            end
            state_in = ST_MATCH;
         end
         ST_PLACE: begin
            if (rem_ff == '0) begin
               state_in = ST_DONE;
            end else if (own_cnt == DEPTH_C) begin
               dropped_in = rem_ff;
               state_in   = ST_DONE;
            end else if (own_cnt == '0) begin
               idx_in   = '0;
               state_in = ST_WRITE;
            end else begin
               idx_in   = own_cnt;
               rd_addr  = phys(own_head, own_cnt - ONE_C);
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            // Insertion from the tail: move worse-priced entries back one slot.
            if (worse) begin
               wr_addr = phys(own_head, idx_ff);
               wr_data = own_rd;
               we_bid  = buy_ff;
               we_ask  = !buy_ff;
               idx_in  = idx_ff - ONE_C;
               if (idx_ff == ONE_C) begin
                  state_in = ST_WRITE;
               end else begin
                  rd_addr = phys(own_head, idx_ff - CW'(2));
               end
            end else begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            wr_addr   = phys(own_head, idx_ff);
            wr_data   = '{price: limit_ff, qty: rem_ff};
            we_bid    = buy_ff;
            we_ask    = !buy_ff;
            rested_in = rem_ff;
            if (buy_ff) begin
               bid_cnt_in = bid_cnt_ff + ONE_C;
               if (idx_ff == '0) begin
                  bid_hp_in = limit_ff;
                  bid_hq_in = rem_ff;
               end
            end else begin
               ask_cnt_in = ask_cnt_ff + ONE_C;
               if (idx_ff == '0) begin
                  ask_hp_in = limit_ff;
                  ask_hq_in = rem_ff;
               end
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                 = 1'b1;
               rsp_data_in.filled_quantity  = qty_ff - rem_ff;
               rsp_data_in.rested_quantity  = rested_ff;
               rsp_data_in.dropped_quantity = dropped_ff;
               rsp_data_in.bid_present      = (bid_cnt_ff != '0);
               rsp_data_in.top_bid_price    = (bid_cnt_ff != '0) ? bid_hp_ff : '0;
               rsp_data_in.ask_present      = (ask_cnt_ff != '0);
               rsp_data_in.top_ask_price    = (ask_cnt_ff != '0) ? ask_hp_ff : '0;
               state_in                     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bid_head_ff  <= '0;
         ask_head_ff  <= '0;
         bid_cnt_ff   <= '0;
         ask_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bid_head_ff  <= bid_head_in;
         ask_head_ff  <= ask_head_in;
         bid_cnt_ff   <= bid_cnt_in;
         ask_cnt_ff   <= ask_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      buy_ff      <= buy_in;
      limit_ff    <= limit_in;
      qty_ff      <= qty_in;
      rem_ff      <= rem_in;
      rested_ff   <= rested_in;
      dropped_ff  <= dropped_in;
      idx_ff      <= idx_in;
      bid_hp_ff   <= bid_hp_in;
      ask_hp_ff   <= ask_hp_in;
      bid_hq_ff   <= bid_hq_in;
      ask_hq_ff   <= ask_hq_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (we_bid) begin
         bid_mem[wr_addr] <= wr_data;
      end
      bid_rd_ff <= bid_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (we_ask) begin
         ask_mem[wr_addr] <= wr_data;
      end
      ask_rd_ff <= ask_mem[rd_addr];
   end

endmodule

>>> hdl/limit_order_matcher.sv
// Limit order matcher, top level over lom_req_fifo and lom_engine; depends on lom_pkg.
// A request first consumes crossing orders from the head of the opposite book, one at a
// time; any remainder then rests by a search from the tail of its own book, moving each
// order it goes ahead of back one slot, and a final write. One request is served at a
// time. Reset is synchronous and active high; both books start empty.
module limit_order_matcher #(
   parameter int BookDepth = lom_pkg::DEFAULT_BOOK_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lom_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lom_pkg::rsp_type rsp_data
);

   // Requests are buffered in a short queue so that intake carries on while the
   // engine walks the books. The engine keeps each book as a circular memory
   // with the head entry cached in registers, so the best prices are always on
   // hand. The result sits in an output register, so a waiting result does not
   // stop the engine from taking the next queued request until it is finished.

   logic             q_valid;
   logic             q_ready;
   lom_pkg::req_type q_data;

   lom_req_fifo u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_data)
   );

   lom_engine #(
      .BookDepth (BookDepth)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_data   (q_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> tb/limit_order_matcher_tb.sv
// Self-checking testbench for limit_order_matcher: drives requests with random gaps,
// predicts each response from a behavioural order book, and compares field by field.
// Depends on lom_pkg and the limit_order_matcher RTL.
`timescale 1ns / 100ps

module limit_order_matcher_tb;

   localparam int DEPTH     = lom_pkg::DEFAULT_BOOK_DEPTH;
   localparam int MAX_CYCLE = 2000000;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   lom_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   lom_pkg::rsp_type rsp_data;

   limit_order_matcher #(.BookDepth(DEPTH)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // The clock runs with a 20 ns period: 10 ns high and 10 ns low.
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // The predictor keeps its own copy of both books. Slot 0 is the best
   // order on each side; entries at or above the count are never read.
   lom_pkg::entry_type model_bids[DEPTH];
   lom_pkg::entry_type model_asks[DEPTH];
   int                 bid_depth;
   int                 ask_depth;
   lom_pkg::rsp_type   pending_fills[$];
   int                 error_count;
   int                 cycle_count;
   bit                 hold_off;

   // Matching is applied to the predictor when a request is accepted, so that
   // the expected responses are queued in the same order as the block serves them.
   function automatic lom_pkg::rsp_type predict_fill(lom_pkg::req_type ord);
      lom_pkg::rsp_type   res;
      logic [31:0]        left;
      lom_pkg::entry_type head;
      int                 pos;
      bit                 crosses;
      left = ord.order_quantity;
      res  = '0;
      // Consume the opposite book from its head while the price crosses.
      forever begin
         if (left == 0) break;
         if (ord.is_buy ? (ask_depth == 0) : (bid_depth == 0)) break;
         head    = ord.is_buy ? model_asks[0] : model_bids[0];
         crosses = ord.is_buy ? (head.price <= ord.limit_price)
                              : (head.price >= ord.limit_price);
         if (!crosses) break;
         if (head.qty > left) begin
            head.qty = head.qty - left;
            left     = 0;
            if (ord.is_buy) model_asks[0] = head;
            else model_bids[0] = head;
         end else begin
            left = left - head.qty;
            if (ord.is_buy) begin
               for (int i = 1; i < ask_depth; i++) model_asks[i-1] = model_asks[i];
               ask_depth--;
            end else begin
               for (int i = 1; i < bid_depth; i++) model_bids[i-1] = model_bids[i];
               bid_depth--;
            end
         end
      end
      res.filled_quantity = ord.order_quantity - left;
      // Any remainder rests behind every order of equal price, unless the
      // own side is already full, in which case it is dropped.
      if (left != 0) begin
         if (ord.is_buy) begin
            if (bid_depth >= DEPTH) res.dropped_quantity = left;
            else begin
               pos = 0;
               while (pos < bid_depth && model_bids[pos].price >= ord.limit_price) pos++;
               for (int i = bid_depth; i > pos; i--) model_bids[i] = model_bids[i-1];
               model_bids[pos] = '{price: ord.limit_price, qty: left};
               bid_depth++;
               res.rested_quantity = left;
            end
         end else begin
            if (ask_depth >= DEPTH) res.dropped_quantity = left;
            else begin
               pos = 0;
               while (pos < ask_depth && model_asks[pos].price <= ord.limit_price) pos++;
               for (int i = ask_depth; i > pos; i--) model_asks[i] = model_asks[i-1];
               model_asks[pos] = '{price: ord.limit_price, qty: left};
               ask_depth++;
               res.rested_quantity = left;
            end
         end
      end
      res.bid_present   = (bid_depth > 0);
      res.top_bid_price = (bid_depth > 0) ? model_bids[0].price : '0;
      res.ask_present   = (ask_depth > 0);
      res.top_ask_price = (ask_depth > 0) ? model_asks[0].price : '0;
      return res;
   endfunction

   // Gap lengths are mostly short, with an occasional long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Sends one request: valid rises at a falling edge and holds until accepted.
   // Valid drops only when a gap follows, so requests can run back to back.
   task automatic send_order(input logic buy, input logic [31:0] price,
                             input logic [31:0] qty, input bit gaps);
      int gap;
      gap = gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  <= '{is_buy: buy, limit_price: price, order_quantity: qty};
      req_valid <= 1'b1;
      forever begin
         @(posedge clock);
         if (req_valid && req_ready) break;
      end
      pending_fills = {pending_fills, predict_fill(req_data)};
      @(negedge clock);
   endtask

   // Receiver side: ready toggles at random unless a long hold-off is running.
   initial begin
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_off) rsp_ready <= 1'b0;
         else rsp_ready <= ($urandom_range(0, 3) != 0);
      end
   end

   // Each accepted response is compared with the oldest expectation.
   always @(posedge clock) begin
      lom_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_fills.size() == 0) begin
            $error("response with no request outstanding");
            error_count++;
         end else begin
            want = pending_fills.pop_front();
            if (rsp_data.filled_quantity !== want.filled_quantity) begin
               $error("filled_quantity: expected %0d, got %0d",
                      want.filled_quantity, rsp_data.filled_quantity);
               error_count++;
            end
            if (rsp_data.rested_quantity !== want.rested_quantity) begin
               $error("rested_quantity: expected %0d, got %0d",
                      want.rested_quantity, rsp_data.rested_quantity);
               error_count++;
            end
            if (rsp_data.dropped_quantity !== want.dropped_quantity) begin
               $error("dropped_quantity: expected %0d, got %0d",
                      want.dropped_quantity, rsp_data.dropped_quantity);
               error_count++;
            end
            if (rsp_data.top_bid_price !== want.top_bid_price) begin
               $error("top_bid_price: expected %0d, got %0d",
                      want.top_bid_price, rsp_data.top_bid_price);
               error_count++;
            end
            if (rsp_data.bid_present !== want.bid_present) begin
               $error("bid_present: expected %0d, got %0d",
                      want.bid_present, rsp_data.bid_present);
               error_count++;
            end
            if (rsp_data.top_ask_price !== want.top_ask_price) begin
               $error("top_ask_price: expected %0d, got %0d",
                      want.top_ask_price, rsp_data.top_ask_price);
               error_count++;
            end
            if (rsp_data.ask_present !== want.ask_present) begin
               $error("ask_present: expected %0d, got %0d",
                      want.ask_present, rsp_data.ask_present);
               error_count++;
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > MAX_CYCLE) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Directed checks on an empty book: zero quantity, extreme prices and
   // quantities, an exact fill, a partial fill and a non-crossing order.
   task automatic test_directed();
      send_order(1'b1, 32'd100, 32'd0, 1'b0);          // zero quantity, empty book
      send_order(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send_order(1'b1, 32'd0, 32'd5, 1'b0);           // below best ask: no match
      send_order(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0); // exact fill of the ask
      send_order(1'b1, 32'd50, 32'd10, 1'b0);
      send_order(1'b1, 32'd50, 32'd7, 1'b0);          // rests behind equal price
      send_order(1'b0, 32'd50, 32'd12, 1'b0);         // consumes one, shrinks next
      send_order(1'b0, 32'd60, 32'd3, 1'b0);          // above best bid: rests
      send_order(1'b0, 32'd0, 32'd0, 1'b0);           // zero quantity reports prices
      send_order(1'b0, 32'd0, 32'd100, 1'b0);         // sweeps the bids, rests at 0
      send_order(1'b1, 32'hFFFF_FFFF, 32'd1000, 1'b0); // sweeps the asks
      send_order(1'b0, 32'd0, 32'h5555_5555, 1'b0);
      send_order(1'b0, 32'h0000_0001, 32'hAAAA_AAAA, 1'b0);
   endtask

   // Fills the ask side to depth so that further sells are dropped, then
   // clears it again with one large buy.
   task automatic test_full_book();
      for (int i = 0; i < DEPTH + 4; i++)
         send_order(1'b0, 32'd1000 + $urandom_range(0, 20), $urandom_range(1, 9), 1'b1);
      send_order(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      for (int i = 0; i < DEPTH + 3; i++)
         send_order(1'b1, $urandom_range(1, 30), $urandom_range(1, 9), 1'b1);
      send_order(1'b0, 32'd0, 32'hFFFF_FFFF, 1'b1);
   endtask

   // The receiver stalls for a long stretch while requests keep coming, so the
   // block fills its queue and holds off the sender.
   task automatic test_backpressure();
      fork
         begin
            hold_off = 1'b1;
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
         begin
            for (int i = 0; i < 20; i++)
               send_order(1'($urandom_range(0, 1)), $urandom_range(90, 110),
                          $urandom_range(1, 50), 1'b0);
            req_valid <= 1'b0;
            @(negedge clock);
         end
      join
   endtask

   // Random orders around a mid price so that most of them cross or rest
   // near the top; a few use full-range values.
   task automatic test_random(input int count);
      logic        buy;
      logic [31:0] price;
      logic [31:0] qty;
      for (int i = 0; i < count; i++) begin
         buy = 1'($urandom_range(0, 1));
         if ($urandom_range(0, 9) == 0) begin
            price = $urandom();
            qty   = $urandom();
         end else begin
            price = 32'd480 + $urandom_range(0, 40);
            qty   = ($urandom_range(0, 19) == 0) ? 32'd0 : $urandom_range(1, 60);
         end
         send_order(buy, price, qty, 1'b1);
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      hold_off    = 1'b0;
      error_count = 0;
      cycle_count = 0;
      bid_depth   = 0;
      ask_depth   = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_full_book();
      test_backpressure();
      test_random(270);
      req_valid <= 1'b0;

      while (pending_fills.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (error_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule

>>> files.f
hdl/lom_pkg.sv
hdl/lom_req_fifo.sv
hdl/lom_engine.sv
hdl/limit_order_matcher.sv
tb/limit_order_matcher_tb.sv
